>>> rtl/core/mirp_pkg.sv
// ----------------------------------------------------------------------------
// mirp_pkg: shared types and constants of the message id rate profiler
// Field widths, beat layouts, status codes and the per-slot statistics record.
// ----------------------------------------------------------------------------
package mirp_pkg;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int AVG_W     = 48;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int WEIGHT_W  = 9;
    localparam int IV_W      = 40;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = AVG_W + WEIGHT_W;

    // Input beat: message_id, now_ms. Output beat: slot, count, average.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [PROD_W:0]     ROUND_HALF   = (PROD_W + 1)'(128);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UPDATED = 2'd0,
        STATUS_ADDED   = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_time;
        logic [AVG_W-1:0]   average;
    } stats_t;

    // Stage strobes for the statistics datapath.
    typedef struct packed {
        logic load;   // capture the read record, form interval and count
        logic mul;    // capture the two weighted products
        logic fresh;  // slot was just claimed: treat its record as cleared
    } upd_ctl_t;

endpackage

>>> rtl/core/mirp_stat_update.sv
// ----------------------------------------------------------------------------
// mirp_stat_update: statistics update datapath
// Two registered stages: interval/count, then weighted products; the final
// rounding add and seed selection feed the write-back.
// ----------------------------------------------------------------------------
module mirp_stat_update (
    input  logic                           aclk,
    input  mirp_pkg::upd_ctl_t             ctl,
    input  mirp_pkg::stats_t               rd_stats,
    input  logic [mirp_pkg::TIME_W-1:0]    now_ms,
    input  logic [mirp_pkg::WEIGHT_W-1:0]  weight,
    output mirp_pkg::stats_t               new_stats
);
    import mirp_pkg::*;

    stats_t              base;
    logic [COUNT_W-1:0]  count_inc;
    logic                take;
    logic [TIME_W-1:0]   diff;
    logic [IV_W-1:0]     iv_sat;
    logic [WEIGHT_W-1:0] weight_sat;

    logic [COUNT_W-1:0]  count_a_reg;
    logic                take_a_reg;
    logic [AVG_W-1:0]    iv_a_reg;
    logic [AVG_W-1:0]    avg_a_reg;
    logic [WEIGHT_W-1:0] weight_a_reg;

    logic [COUNT_W-1:0]  count_b_reg;
    logic                take_b_reg;
    logic [AVG_W-1:0]    iv_b_reg;
    logic [AVG_W-1:0]    avg_b_reg;
    logic [PROD_W-1:0]   prod_old_reg;
    logic [PROD_W-1:0]   prod_new_reg;

    logic [PROD_W:0]     blend_sum;
    logic [AVG_W-1:0]    avg_new;

    always_comb begin
        base       = ctl.fresh ? '0 : rd_stats;
        count_inc  = (base.count == COUNT_MAX) ? base.count : base.count + 1'b1;
        take       = (base.last_time != '0) && (now_ms >= base.last_time);
        diff       = now_ms - base.last_time;
        iv_sat     = (|diff[TIME_W-1:IV_W]) ? '1 : diff[IV_W-1:0];
        weight_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            count_a_reg  <= count_inc;
            take_a_reg   <= take;
            iv_a_reg     <= {iv_sat, {FRAC_W{1'b0}}};
            avg_a_reg    <= base.average;
            weight_a_reg <= weight_sat;
        end
        if (ctl.mul) begin
            count_b_reg  <= count_a_reg;
            take_b_reg   <= take_a_reg;
            iv_b_reg     <= iv_a_reg;
            avg_b_reg    <= avg_a_reg;
            prod_old_reg <= PROD_W'(avg_a_reg) * PROD_W'(WEIGHT_ONE - weight_a_reg);
            prod_new_reg <= PROD_W'(iv_a_reg) * PROD_W'(weight_a_reg);
        end
    end

    // Round half up, drop the fraction; the first interval seeds the average.
    always_comb begin
        blend_sum = (PROD_W + 1)'(prod_old_reg) + (PROD_W + 1)'(prod_new_reg) + ROUND_HALF;
        if (!take_b_reg) begin
            avg_new = avg_b_reg;
        end else if (avg_b_reg == '0) begin
            avg_new = iv_b_reg;
        end else begin
            avg_new = blend_sum[FRAC_W +: AVG_W];
        end
        new_stats.count     = count_b_reg;
        new_stats.last_time = now_ms;
        new_stats.average   = avg_new;
    end

endmodule

>>> rtl/core/message_id_rate_profiler_core.sv
// ----------------------------------------------------------------------------
// message_id_rate_profiler_core: per-id message count and inter-arrival average
// Table of ENTRIES message ids with a saturating count, last-seen time and an
// exponential average of the arrival interval in Q40.8 milliseconds.
// ----------------------------------------------------------------------------
// Each input beat carries one observed message (id, millisecond timestamp) and
// yields exactly one output beat. Ids live in a one-port synchronous memory
// that is searched one entry per cycle from slot 0 up to the fill count; slots
// are never released, so the occupied slots are always a prefix and the next
// free slot is the fill count itself, which reset clears (no clearing pass).
// Timing depends on the linear id scan through the single read port of the id
// memory: a hit in slot k ends the scan there, a new id scans all held ids,
// and a message dropped on a full table scans all ENTRIES slots first.
// The statistics memory is read once on a hit and written once per stored
// message; the result register lets the next message enter while a result waits.
// A weight above 256 is used as 256. Write the weight only while idle.
module message_id_rate_profiler_core #(
    parameter int ENTRIES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mirp_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] message_id, [63:16] now_ms
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mirp_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] slot, [37:6] message_count,
                                                        // [85:38] interval_average_q8, [87:86] 0
    output logic [mirp_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
    // smoothing weight register
    input  logic                             cfg_wr_en,
    input  logic [mirp_pkg::WEIGHT_W-1:0]    cfg_wr_data
);
    import mirp_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // slot index width
    localparam int CW = $clog2(ENTRIES + 1);                    // fill count width

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    // Memories: id per slot, statistics record per slot.
    logic [ID_W-1:0] id_mem    [ENTRIES];
    stats_t          stats_mem [ENTRIES];

    state_t              state_reg,     state_next;
    logic [ID_W-1:0]     key_id_reg,    key_id_next;
    logic [TIME_W-1:0]   key_now_reg,   key_now_next;
    logic [WEIGHT_W-1:0] weight_reg,    weight_next;
    logic [CW-1:0]       fill_reg,      fill_next;
    logic [CW-1:0]       issue_reg,     issue_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [SW-1:0]       cmp_addr_reg,  cmp_addr_next;
    logic [SW-1:0]       slot_reg,      slot_next;
    logic                fresh_reg,     fresh_next;
    logic                full_reg,      full_next;
    logic                m_tvalid_reg,  m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg,   m_tuser_next;

    logic [ID_W-1:0]     id_rd_reg;
    stats_t              stats_rd_reg;

    logic     in_acc;
    logic     match;
    logic     issue;
    logic     out_free;
    logic     stats_rd_en;
    logic     wr_en;
    upd_ctl_t upd_ctl;
    stats_t   new_stats;
    status_t  status;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    // Compare the id read last cycle; issue the next read while no hit is seen.
    assign match    = cmp_valid_reg && (id_rd_reg == key_id_reg);
    assign issue    = (state_reg == ST_SCAN) && !match && (issue_reg < fill_reg);
    assign wr_en    = (state_reg == ST_FIN) && out_free && !full_reg;

    always_comb begin
        status = STATUS_UPDATED;
        if (full_reg) begin
            status = STATUS_FULL;
        end else if (fresh_reg) begin
            status = STATUS_ADDED;
        end
    end

    always_comb begin
        state_next     = state_reg;
        key_id_next    = key_id_reg;
        key_now_next   = key_now_reg;
        weight_next    = weight_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_addr_next  = cmp_addr_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        full_next      = full_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        stats_rd_en    = 1'b0;
        upd_ctl.load   = 1'b0;
        upd_ctl.mul    = 1'b0;
        upd_ctl.fresh  = fresh_reg;

        if (cfg_wr_en) begin
            weight_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    key_id_next  = s_tdata[ID_W-1:0];
                    key_now_next = s_tdata[ID_W +: TIME_W];
                    issue_next   = '0;
                    full_next    = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_valid_next = issue;
                cmp_addr_next  = issue_reg[SW-1:0];
                if (issue) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (match) begin
                    // hit: fetch the slot's record
                    slot_next   = cmp_addr_reg;
                    fresh_next  = 1'b0;
                    stats_rd_en = 1'b1;
                    state_next  = ST_LOAD;
                end else if (!issue && !cmp_valid_reg) begin
                    // scan exhausted: claim the next free slot or drop
                    if (fill_reg == CW'(ENTRIES)) begin
                        full_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        slot_next  = fill_reg[SW-1:0];
                        fresh_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                upd_ctl.load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                upd_ctl.mul = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                // hold until the result register frees up, then commit
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status;
                    if (full_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {{(M_TDATA_W - SLOT_W - COUNT_W - AVG_W){1'b0}},
                                        new_stats.average, new_stats.count,
                                        SLOT_W'(slot_reg)};
                        if (fresh_reg) begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            weight_reg    <= WEIGHT_RESET;
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            full_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            weight_reg    <= weight_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            fresh_reg     <= fresh_next;
            full_reg      <= full_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_id_reg   <= key_id_next;
        key_now_reg  <= key_now_next;
        cmp_addr_reg <= cmp_addr_next;
        slot_reg     <= slot_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Id memory: one read per scan step, written when a slot is claimed.
    always_ff @(posedge aclk) begin
        if (issue) begin
            id_rd_reg <= id_mem[issue_reg[SW-1:0]];
        end
        if (wr_en && fresh_reg) begin
            id_mem[slot_reg] <= key_id_reg;
        end
    end

    // Statistics memory: read on a hit, written back at commit.
    always_ff @(posedge aclk) begin
        if (stats_rd_en) begin
            stats_rd_reg <= stats_mem[cmp_addr_reg];
        end
        if (wr_en) begin
            stats_mem[slot_reg] <= new_stats;
        end
    end

    mirp_stat_update u_update (
        .aclk      (aclk),
        .ctl       (upd_ctl),
        .rd_stats  (stats_rd_reg),
        .now_ms    (key_now_reg),
        .weight    (weight_reg),
        .new_stats (new_stats)
    );

endmodule

>>> tb/message_id_rate_profiler_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_id_rate_profiler_core_test: self-checking bench for the rate profiler
// Feeds timestamped message beats, predicts every result beat from a private
// model of the id table (count, last-seen time and Q40.8 interval average)
// and compares each result field by field, with random idling on both streams
// and several smoothing weights written between drained phases.
// ----------------------------------------------------------------------------
module message_id_rate_profiler_core_test;
    import mirp_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int POOL_SIZE = 80;      // more ids than slots, so the table fills
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 138;
    localparam logic [63:0] IV_MAX = (64'd1 << IV_W) - 64'd1;

    // One predicted result beat.
    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
        logic [AVG_W-1:0]    average;
    } profile_t;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the id table plus the queue of results due.
    // ------------------------------------------------------------------------
    class rate_scoreboard;
        bit                  taken[ENTRIES];
        logic [ID_W-1:0]     slot_id[ENTRIES];
        logic [COUNT_W-1:0]  slot_count[ENTRIES];
        logic [TIME_W-1:0]   slot_last[ENTRIES];
        logic [AVG_W-1:0]    slot_avg[ENTRIES];
        logic [WEIGHT_W-1:0] weight;
        profile_t            due[$];
        int                  errors;
        int                  n_added;
        int                  n_updated;
        int                  n_dropped;

        function new();
            foreach (taken[i]) taken[i] = 1'b0;
            weight    = WEIGHT_RESET;
            errors    = 0;
            n_added   = 0;
            n_updated = 0;
            n_dropped = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Look up the id, claim a slot if needed, refresh its statistics.
        function void note_input(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
            int          hit;
            int          free_slot;
            logic [63:0] iv;
            logic [63:0] w;
            logic [63:0] avg;
            profile_t    res;
            hit       = -1;
            free_slot = -1;
            for (int s = 0; s < ENTRIES; s++) begin
                if (taken[s]) begin
                    if (hit < 0 && slot_id[s] == id)
                        hit = s;
                end else if (free_slot < 0) begin
                    free_slot = s;
                end
            end
            res.status = STATUS_UPDATED;
            if (hit < 0) begin
                if (free_slot < 0) begin
                    // full table: drop, all other fields zero, no state change
                    res = '{STATUS_FULL, '0, '0, '0};
                    due.push_back(res);
                    n_dropped++;
                    return;
                end
                hit             = free_slot;
                taken[hit]      = 1'b1;
                slot_id[hit]    = id;
                slot_count[hit] = '0;
                slot_last[hit]  = '0;
                slot_avg[hit]   = '0;
                res.status      = STATUS_ADDED;
                n_added++;
            end else begin
                n_updated++;
            end

            if (slot_count[hit] != COUNT_MAX)
                slot_count[hit] = slot_count[hit] + 1'b1;

            // interval only from a nonzero last time that is not in the future
            if (slot_last[hit] != '0 && now >= slot_last[hit]) begin
                iv = 64'(now) - 64'(slot_last[hit]);
                if (iv > IV_MAX)
                    iv = IV_MAX;
                iv  = iv << FRAC_W;
                w   = (weight > WEIGHT_ONE) ? 64'd256 : 64'(weight);
                if (slot_avg[hit] == '0)
                    avg = iv;
                else
                    avg = (64'(slot_avg[hit]) * (64'd256 - w) + iv * w + 64'd128) >> 8;
                slot_avg[hit] = avg[AVG_W-1:0];
            end
            slot_last[hit] = now;

            res.slot    = hit[SLOT_W-1:0];
            res.count   = slot_count[hit];
            res.average = slot_avg[hit];
            due.push_back(res);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, field, got, want);
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(logic [M_TDATA_W-1:0] data, logic [STATUS_W-1:0] user);
            profile_t want;
            if (due.size() == 0) begin
                report("unsolicited result", data[63:0], 64'd0);
                return;
            end
            want = due.pop_front();
            if (user !== want.status)
                report("status", 64'(user), 64'(want.status));
            if (data[5:0] !== want.slot)
                report("slot", 64'(data[5:0]), 64'(want.slot));
            if (data[37:6] !== want.count)
                report("message_count", 64'(data[37:6]), 64'(want.count));
            if (data[85:38] !== want.average)
                report("interval_average_q8", 64'(data[85:38]), 64'(want.average));
            if (data[87:86] !== 2'b00)
                report("tdata padding", 64'(data[87:86]), 64'd0);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // [15:0] message_id, [63:16] now_ms
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // [5:0] slot, [37:6] count, [85:38] average
    logic [STATUS_W-1:0]    m_tuser;            // [1:0] status
    logic                   cfg_wr_en   = 1'b0;
    logic [WEIGHT_W-1:0]    cfg_wr_data = '0;

    rate_scoreboard         sb = new();

    logic [ID_W-1:0]        id_pool[POOL_SIZE];
    logic [TIME_W-1:0]      stamp   = 48'd1000;   // running wall clock for random traffic
    bit                     no_gaps = 1'b0;       // set to run a phase with no idling
    int                     n_weights = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    message_id_rate_profiler_core #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then a long stall.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps)
            return 0;
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check the result beat first, then note the input beat, so a
    // stray result can never be matched against a prediction of this edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[ID_W-1:0], s_tdata[ID_W +: TIME_W]);
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: drop ready for a random stall, then hold it for a while.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Send one message beat: idle for a random gap, then hold valid until taken.
    // Valid stays high straight into the next beat when the next gap is zero.
    task automatic send_msg(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, let the monitor note the last beat, wait for every predicted
    // result, then let the search settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
    endtask

    // Write the smoothing weight (block idle) and mirror it in the predictor.
    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.weight = w;
        n_weights++;
    endtask

    // Timestamp for random traffic: mostly forward steps of the running clock,
    // with big jumps (interval saturation), backward steps, zero, repeats and
    // fully random values mixed in.
    function automatic logic [TIME_W-1:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            stamp = stamp + TIME_W'($urandom_range(1, 2000));
            return stamp;
        end
        if (r < 82) begin
            stamp = stamp + (TIME_W'($urandom_range(1, 255)) << 40);
            return stamp;
        end
        if (r < 88)
            return stamp - TIME_W'($urandom_range(1, 500));
        if (r < 92)
            return '0;
        if (r < 96)
            return TIME_W'({$urandom(), $urandom()});
        return stamp;
    endfunction

    // Ids: the pool in use widens phase by phase so the table fills midway;
    // a few fully random ids land as new entries or drops.
    function automatic logic [ID_W-1:0] pick_id(int phase);
        int lim;
        lim = 20 + phase * 12;
        if (lim > POOL_SIZE)
            lim = POOL_SIZE;
        if ($urandom_range(0, 99) < 3)
            return ID_W'($urandom_range(0, 65535));
        return id_pool[$urandom_range(0, lim - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [WEIGHT_W-1:0] w;

        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'h8000;
        id_pool[3] = 16'h1234;
        id_pool[4] = 16'h5555;
        id_pool[5] = 16'hAAAA;
        for (int i = 6; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom_range(0, 65535));

        // hold reset, then release
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset weight.
        // zero time: nothing taken from a stored zero, zero gets stored
        send_msg(16'h0000, 48'd0);
        send_msg(16'h0000, 48'd100);
        // first interval seeds the average, the next one is blended
        send_msg(16'h0000, 48'd300);
        send_msg(16'h0000, 48'd400);
        // time steps backward: no interval, last time still follows
        send_msg(16'h0000, 48'd350);
        send_msg(16'h0000, 48'd0);
        send_msg(16'h0000, 48'd50);
        // interval saturates at 40 bits, then a zero interval blends in
        send_msg(16'hFFFF, 48'd1);
        send_msg(16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_msg(16'hFFFF, 48'hFFFF_FFFF_FFFF);
        // single-tick interval with the top time bit set
        send_msg(16'h8000, 48'h8000_0000_0000);
        send_msg(16'h8000, 48'h8000_0000_0001);
        // repeated time gives a zero average, so the next interval seeds again
        send_msg(16'h1234, 48'd10);
        send_msg(16'h1234, 48'd10);
        send_msg(16'h1234, 48'd20);
        send_msg(16'h1234, 48'd25);
        // alternating bit patterns in both fields
        send_msg(16'h5555, 48'h5555_5555_5555);
        send_msg(16'hAAAA, 48'hAAAA_AAAA_AAAA);
        send_msg(16'h5555, 48'h5555_5555_6555);
        send_msg(16'hAAAA, 48'hAAAA_AAAA_BAAA);

        // Random phases, each under its own weight: none, full, above full
        // (saturates), minimal, just under full, then a random one.
        // Phases two and five run without any idling.
        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1: begin
                    w = 9'd0;
                end
                2: begin
                    w = WEIGHT_ONE;
                end
                3: begin
                    w = 9'd511;
                end
                4: begin
                    w = 9'd1;
                end
                5: begin
                    w = 9'd255;
                end
                default: begin
                    w = WEIGHT_W'($urandom_range(2, 254));
                end
            endcase
            drain();
            write_weight(w);
            no_gaps = (p == 2 || p == 5);
            repeat (PHASE_LEN) send_msg(pick_id(p), next_stamp());
        end

        drain();
        $display("covered %0d messages: %0d added, %0d updated, %0d dropped on a full table",
                 sb.n_added + sb.n_updated + sb.n_dropped, sb.n_added, sb.n_updated,
                 sb.n_dropped);
        $display("swept %0d smoothing weights; %0d mismatches", n_weights + 1, sb.errors);
        if (sb.errors == 0) begin
            $display("message_id_rate_profiler_core regression: pass");
        end else begin
            $display("message_id_rate_profiler_core regression: fail");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("message_id_rate_profiler_core regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mirp_pkg.sv
rtl/core/mirp_stat_update.sv
rtl/core/message_id_rate_profiler_core.sv
tb/message_id_rate_profiler_core_test.sv
